// File: rtl/iqdfr_pkg.sv
// ----------------------------------------------------------------------------
// iqdfr_pkg
// Types, constants and codes shared by the IQ datagram deframer modules.
// ----------------------------------------------------------------------------
package iqdfr_pkg;

    localparam int SAMPLES_PER_FRAME_DEF = 63;
    localparam int FRAME_BYTES           = 512;
    localparam int FRAME_AW              = $clog2(FRAME_BYTES);
    localparam int POS_W                 = 11;
    localparam int SLOT_W                = FRAME_AW - 3;
    localparam int QUEUE_DEPTH           = 4;

    localparam logic [POS_W-1:0] HDR_LEN = POS_W'(8);
    localparam logic [POS_W-1:0] PKT_END = POS_W'(8 + 2 * FRAME_BYTES);

    localparam logic [7:0] SIG_BYTE0 = 8'hEF;
    localparam logic [7:0] SIG_BYTE1 = 8'hFE;
    localparam logic [7:0] SYNC_BYTE = 8'h7F;

    localparam logic [11:0] COUNT_MAX      = 12'hFFF;
    localparam logic [11:0] BLOCK_SIZE_RST = 12'd240;
    localparam logic [7:0]  PKT_TYPE_RST   = 8'd1;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_TYPE = 8'd1;

    localparam logic OP_SHIFT = 1'b0;
    localparam logic OP_EMIT  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] sample_real;
        logic signed [23:0] sample_imag;
        logic               block_end;
    } out_item_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last_slot;
    } cmd_t;

endpackage

// File: rtl/iqdfr_front.sv
// ----------------------------------------------------------------------------
// iqdfr_front
// Tracks datagram offset, checks header and frame sync, and issues slot
// byte commands to the back end.
// ----------------------------------------------------------------------------
module iqdfr_front #(
    parameter int SAMPLES_PER_FRAME = iqdfr_pkg::SAMPLES_PER_FRAME_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  iqdfr_pkg::in_item_t in_item,
    input  logic [7:0]         packet_type,
    output logic               cmd_push,
    output iqdfr_pkg::cmd_t    cmd
);
    import iqdfr_pkg::*;

    localparam logic [SLOT_W-1:0] SPF = SLOT_W'(SAMPLES_PER_FRAME);

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                pkt_ok_reg, pkt_ok_next;
    logic                frm_ok_reg, frm_ok_next;

    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    pos_hdr;
    logic [FRAME_AW-1:0] f;
    logic [FRAME_AW-1:0] rel;
    logic [SLOT_W-1:0]   slot;
    logic [2:0]          sub;
    logic [7:0]          b;

    always_comb begin
        b        = in_item.data_byte;
        pos      = in_item.packet_start ? '0 : pos_reg;
        pos_hdr  = pos - HDR_LEN;
        f        = pos_hdr[FRAME_AW-1:0];
        rel      = f - FRAME_AW'(8);
        slot     = rel[FRAME_AW-1:3];
        sub      = rel[2:0];

        pos_next    = pos_reg;
        pkt_ok_next = pkt_ok_reg;
        frm_ok_next = frm_ok_reg;
        cmd_push    = 1'b0;
        cmd.op        = OP_SHIFT;
        cmd.data_byte = b;
        cmd.last_slot = (slot == SPF - SLOT_W'(1));

        if (in_fire) begin
            pos_next = pos;
            if (pos < PKT_END) begin
                pos_next = pos + POS_W'(1);
                if (pos == POS_W'(0)) begin
                    pkt_ok_next = in_item.packet_start && (b == SIG_BYTE0);
                end else if (pos == POS_W'(1)) begin
                    pkt_ok_next = pkt_ok_reg && (b == SIG_BYTE1);
                end else if (pos == POS_W'(2)) begin
                    pkt_ok_next = pkt_ok_reg && (b == packet_type);
                end else if (pos >= HDR_LEN && pkt_ok_reg) begin
                    if (f == '0) begin
                        frm_ok_next = (b == SYNC_BYTE);
                    end else if (f < FRAME_AW'(3)) begin
                        frm_ok_next = frm_ok_reg && (b == SYNC_BYTE);
                    end else if (f >= FRAME_AW'(8) && frm_ok_reg && slot < SPF) begin
                        if (sub < 3'd5) begin
                            cmd_push = 1'b1;
                            cmd.op   = OP_SHIFT;
                        end else if (sub == 3'd5) begin
                            cmd_push = 1'b1;
                            cmd.op   = OP_EMIT;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            pkt_ok_reg <= 1'b0;
            frm_ok_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            pkt_ok_reg <= pkt_ok_next;
            frm_ok_reg <= frm_ok_next;
        end
    end

endmodule

// File: rtl/iqdfr_fifo.sv
// ----------------------------------------------------------------------------
// iqdfr_fifo
// Short command queue between the classifier and the sample assembler.
// ----------------------------------------------------------------------------
module iqdfr_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  iqdfr_pkg::cmd_t push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output iqdfr_pkg::cmd_t pop_cmd
);
    import iqdfr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    cmd_t          mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;

    always_comb begin
        full      = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
        not_empty = (cnt_reg != '0);
        pop_cmd   = mem[rd_reg];
        wr_next   = push ? wr_reg + AW'(1) : wr_reg;
        rd_next   = pop ? rd_reg + AW'(1) : rd_reg;
        cnt_next  = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/iqdfr_back.sv
// ----------------------------------------------------------------------------
// iqdfr_back
// Assembles slot bytes into I/Q samples, counts block length and holds the
// result register.
// ----------------------------------------------------------------------------
module iqdfr_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_avail,
    input  iqdfr_pkg::cmd_t      cmd,
    output logic                 cmd_pop,
    input  logic [11:0]          block_size,
    output logic                 m_valid,
    input  logic                 m_ready,
    output iqdfr_pkg::out_item_t m_item
);
    import iqdfr_pkg::*;

    logic [39:0] held_reg, held_next;
    logic [11:0] cnt_reg, cnt_next;
    logic        vld_reg, vld_next;
    out_item_t   item_reg, item_next;
    logic [11:0] cnt_inc;
    logic        bend;

    always_comb begin
        cmd_pop   = cmd_avail && (!vld_reg || m_ready);
        held_next = held_reg;
        cnt_next  = cnt_reg;
        item_next = item_reg;
        vld_next  = vld_reg && !m_ready;
        cnt_inc   = (cnt_reg < COUNT_MAX) ? cnt_reg + 12'd1 : cnt_reg;
        bend      = cmd.last_slot && (cnt_inc >= block_size);

        if (cmd_pop) begin
            if (cmd.op == OP_SHIFT) begin
                held_next = {held_reg[31:0], cmd.data_byte};
            end else begin
                vld_next              = 1'b1;
                item_next.sample_imag = held_reg[39:16];
                item_next.sample_real = {held_reg[15:0], cmd.data_byte};
                item_next.block_end   = bend;
                cnt_next              = bend ? 12'd0 : cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (!aresetn) begin
            held_reg <= '0;
            cnt_reg  <= '0;
            vld_reg  <= 1'b0;
        end else begin
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
            vld_reg  <= vld_next;
        end
    end

    assign m_valid = vld_reg;
    assign m_item  = item_reg;

endmodule

// File: rtl/sdr_udp_iq_frame_deframer.sv
// ----------------------------------------------------------------------------
// sdr_udp_iq_frame_deframer
// IQ datagram deframer: bytes in, signed 24-bit I/Q samples out.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one datagram byte per item; packet_start
//   marks the first byte. An 8-byte header (EF FE type ...) is checked, then
//   two 512-byte frames with 7F 7F 7F sync; each 8-byte slot yields one
//   sample on m_valid/m_ready/m_item, with block_end on the last slot of a
//   frame once block_size samples have gone out.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write block_size (0) and
//   packet_type (1); cfg_ready is always high. Write only while idle.
// Throughput: one byte per cycle while the queue is not full. Path: the
//   sixth slot byte goes through the queue write, then the result register
//   raises m_valid, later while older commands wait in the 4-entry queue.
// Reset: clears offset, header/sync flags, block count and the queue;
//   registers return to block_size 240, packet_type 1.
// Stall: a stalled result holds; the queue keeps taking bytes until full,
//   then s_ready drops.
// ----------------------------------------------------------------------------
module sdr_udp_iq_frame_deframer #(
    parameter int SAMPLES_PER_FRAME = iqdfr_pkg::SAMPLES_PER_FRAME_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  iqdfr_pkg::in_item_t                 s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output iqdfr_pkg::out_item_t                m_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iqdfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iqdfr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import iqdfr_pkg::*;

    logic [11:0] block_size_reg;
    logic [7:0]  packet_type_reg;
    logic        q_full;
    logic        q_avail;
    logic        q_pop;
    logic        cmd_push;
    cmd_t        cmd_in;
    cmd_t        cmd_out;
    logic        in_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign in_fire   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg  <= BLOCK_SIZE_RST;
            packet_type_reg <= PKT_TYPE_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_BLOCK_SIZE) begin
                block_size_reg <= cfg_data[11:0];
            end else if (cfg_index == CFG_PACKET_TYPE) begin
                packet_type_reg <= cfg_data[7:0];
            end
        end
    end

    iqdfr_front #(
        .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_item    (s_item),
        .packet_type(packet_type_reg),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    iqdfr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (cmd_in),
        .pop      (q_pop),
        .full     (q_full),
        .not_empty(q_avail),
        .pop_cmd  (cmd_out)
    );

    iqdfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_avail (q_avail),
        .cmd       (cmd_out),
        .cmd_pop   (q_pop),
        .block_size(block_size_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
